// ----- rtl/amre_pkg.sv -----
// Package: shared types, constants and helper functions for the alpha mask run encoder.
`default_nettype none

package amre_pkg;

  // Coverage level codes of a quantized alpha byte.
  typedef enum logic [1:0] {
    LVL_NONE = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_HIGH = 2'd2,
    LVL_FULL = 2'd3
  } level_e;

  // Quantizer thresholds.
  localparam logic [7:0] THR_LOW  = 8'd24;
  localparam logic [7:0] THR_HIGH = 8'd112;
  localparam logic [7:0] THR_FULL = 8'd208;

  // Coverage of each level.
  localparam logic [7:0] COV_LOW  = 8'd80;
  localparam logic [7:0] COV_HIGH = 8'd176;
  localparam logic [7:0] COV_FULL = 8'd255;

  // Rounding offset of the divide by 255.
  localparam logic [7:0] DIV_ROUND = 8'd127;

  // Output field widths.
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned START_W = 4;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned COLOR_W = 32;

  // Result queue depth (in pixels, each holding up to two runs).
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] color;
  } run_t;

  // One queue entry: the runs closed by one pixel.
  typedef struct packed {
    run_t run1;
    run_t run0;
    logic two;
  } entry_t;

  function automatic level_e quantize(input logic [7:0] a);
    level_e l;
    if (a < THR_LOW) begin
      l = LVL_NONE;
    end else if (a < THR_HIGH) begin
      l = LVL_LOW;
    end else if (a < THR_FULL) begin
      l = LVL_HIGH;
    end else begin
      l = LVL_FULL;
    end
    return l;
  endfunction

  function automatic logic [7:0] level_coverage(input level_e l);
    logic [7:0] c;
    case (l)
      LVL_LOW:  c = COV_LOW;
      LVL_HIGH: c = COV_HIGH;
      LVL_FULL: c = COV_FULL;
      default:  c = 8'd0;
    endcase
    return c;
  endfunction

  // round(a * coverage / 255); divide by 255 as (x + (x >> 8) + 1) >> 8,
  // exact for x below 65280, where the 16-bit sum does not wrap.
  function automatic logic [7:0] scale_alpha(input logic [7:0] a, input level_e l);
    logic [15:0] x;
    logic [15:0] q;
    x = 16'(a) * 16'(level_coverage(l)) + 16'(DIV_ROUND);
    q = 16'(x + (x >> 8) + 16'd1) >> 8;
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/alpha_mask_run_encoder_top.sv -----
// Top level: quantized run-length encoder for square alpha masks.
// Throughput: one pixel per cycle. Only a row's last column closes two runs and the next
// pixel closes none, so the one-run-per-cycle output keeps up while out_ready_i is high.
// A two-entry pixel queue parts input from output; input stalls only while both entries wait.
// Reset: position, open run and queue clear; draw color goes to all ones.
`default_nettype none

module alpha_mask_run_encoder_top #(
  parameter int unsigned MASK_SIZE = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_draw_color_i,
  // pixel input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  mask_alpha_i,
  // run output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       run_row_o,
  output logic [3:0]       run_start_o,
  output logic [4:0]       run_length_o,
  output logic [31:0]      run_color_o,
  output logic             last_of_item_o
);

  localparam int unsigned CW = $clog2(MASK_SIZE);
  localparam int unsigned LW = $clog2(MASK_SIZE + 1);
  localparam int unsigned PW = $clog2(amre_pkg::QDEPTH);
  localparam int unsigned NW = $clog2(amre_pkg::QDEPTH + 1);

  localparam logic [CW-1:0] LAST_POS = CW'(MASK_SIZE - 1);
  localparam logic [LW-1:0] SIZE_LEN = LW'(MASK_SIZE);

  // Configuration register; the user must send writes only while idle, as the block does not enforce it.
  logic [31:0] draw_color_q;

  // Scan position and open run.
  logic [CW-1:0]        row_q, row_d;
  logic [CW-1:0]        col_q, col_d;
  logic [CW-1:0]        begin_q, begin_d;
  amre_pkg::level_e     level_q, level_d;

  // Pixel queue.
  amre_pkg::entry_t     queue_q [amre_pkg::QDEPTH];
  logic [PW-1:0]        wptr_q, rptr_q;
  logic [NW-1:0]        count_q;
  logic                 sub_q;

  logic                 in_fire, push, pop, out_fire;
  amre_pkg::level_e     lvl;
  logic                 emit0, emit1, row_end;
  logic [LW-1:0]        len0, len1;
  amre_pkg::run_t       run0, run1;
  amre_pkg::entry_t     new_entry, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_color_q <= 32'hffff_ffff;
    end else if (cfg_valid_i) begin
      draw_color_q <= cfg_draw_color_i;
    end
  end

  // Accept a pixel whenever a queue slot is free.
  assign in_ready_o = (count_q != NW'(amre_pkg::QDEPTH));
  assign in_fire    = in_valid_i & in_ready_o;

  // Close runs and advance the scan position for the incoming pixel.
  always_comb begin
    lvl     = amre_pkg::quantize(mask_alpha_i);
    row_end = (col_q == LAST_POS);

    // A level change mid-row closes the open run first.
    emit0 = (col_q != '0) && (lvl != level_q) && (level_q != amre_pkg::LVL_NONE);
    len0  = LW'({1'b0, col_q}) - LW'({1'b0, begin_q});
    run0.row   = amre_pkg::ROW_W'(row_q);
    run0.start = amre_pkg::START_W'(begin_q);
    run0.len   = amre_pkg::LEN_W'(len0);
    run0.color = {amre_pkg::scale_alpha(draw_color_q[31:24], level_q), draw_color_q[23:0]};

    // Open a new run at row start or on a level change.
    begin_d = begin_q;
    level_d = level_q;
    if (col_q == '0) begin
      begin_d = '0;
      level_d = lvl;
    end else if (lvl != level_q) begin
      begin_d = col_q;
      level_d = lvl;
    end

    // The last column closes whatever run is open, this pixel included.
    emit1 = row_end && (level_d != amre_pkg::LVL_NONE);
    len1  = SIZE_LEN - LW'({1'b0, begin_d});
    run1.row   = amre_pkg::ROW_W'(row_q);
    run1.start = amre_pkg::START_W'(begin_d);
    run1.len   = amre_pkg::LEN_W'(len1);
    run1.color = {amre_pkg::scale_alpha(draw_color_q[31:24], level_d), draw_color_q[23:0]};

    row_d = row_q;
    col_d = col_q + CW'(1);
    if (row_end) begin
      col_d   = '0;
      begin_d = '0;
      row_d   = (row_q == LAST_POS) ? '0 : row_q + CW'(1);
    end

    // Pack the runs so the first one always sits in slot zero.
    new_entry.two  = emit0 & emit1;
    new_entry.run0 = emit0 ? run0 : run1;
    new_entry.run1 = run1;
  end

  assign push = in_fire & (emit0 | emit1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      begin_q <= '0;
      level_q <= amre_pkg::LVL_NONE;
    end else if (in_fire) begin
      row_q   <= row_d;
      col_q   <= col_d;
      begin_q <= begin_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= new_entry;
    end
  end

  // Drive the head run; drop the entry after its last run is taken.
  assign head           = queue_q[rptr_q];
  assign out_valid_o    = (count_q != '0);
  assign last_of_item_o = ~head.two | sub_q;
  assign out_fire       = out_valid_o & out_ready_i;
  assign pop            = out_fire & last_of_item_o;

  always_comb begin
    if (sub_q) begin
      run_row_o    = head.run1.row;
      run_start_o  = head.run1.start;
      run_length_o = head.run1.len;
      run_color_o  = head.run1.color;
    end else begin
      run_row_o    = head.run0.row;
      run_start_o  = head.run0.start;
      run_length_o = head.run0.len;
      run_color_o  = head.run0.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
      sub_q   <= 1'b0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + NW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - NW'(1);
      end
      if (out_fire) begin
        sub_q <= ~last_of_item_o;
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/alpha_mask_run_encoder_top_tb.sv -----
// Testbench for the alpha mask run encoder: directed pixels and random runs against a predictor.
`timescale 1ns / 1ps

module alpha_mask_run_encoder_top_tb;

  localparam int unsigned MASK = 16;
  localparam int STALL_LIMIT = 2000;   // cycles with no transaction on any channel
  localparam int SETTLE_CYCLES = 4;    // margin after the last expected run comes out
  localparam int HOLD_CYCLES = 60;     // long receiver hold-off, fills the pixel queue
  localparam int SEG_PIXELS = 64;
  localparam int PREDICTED = -1;       // directed pixel whose runs come from the predictor

  // One expected run, in port order.
  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  start;
    logic [4:0]  len;
    logic [31:0] color;
    logic        last;
  } span_t;

  typedef struct {
    logic [7:0] alpha;
    int         n_typed;
    span_t      s0;
    span_t      s1;
  } dir_pixel_t;

  // Block inputs, known from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_color = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  mask_alpha = '0;
  logic        out_ready = 1'b0;

  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  run_row;
  logic [3:0]  run_start;
  logic [4:0]  run_length;
  logic [31:0] run_color;
  logic        last_of_item;

  // Typed expectation riding along with the pixel on the input channel.
  int    cur_n_typed = PREDICTED;
  span_t cur_s0 = '0;
  span_t cur_s1 = '0;

  // Predictor state.
  logic [31:0]        color_q = 32'hFFFF_FFFF;
  int                 pix_row = 0;
  int                 pix_col = 0;
  int                 open_start = 0;
  amre_pkg::level_e   open_level = amre_pkg::LVL_NONE;

  span_t      pending_spans [$];
  dir_pixel_t directed_pixels [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;
  int rx_hold_left = 0;
  int idle_cycles = 0;
  int n_errors = 0;
  int pixels_seen = 0;
  int runs_seen = 0;

  alpha_mask_run_encoder_top #(
    .MASK_SIZE(MASK)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_draw_color_i(cfg_color),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mask_alpha_i    (mask_alpha),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .run_row_o       (run_row),
    .run_start_o     (run_start),
    .run_length_o    (run_length),
    .run_color_o     (run_color),
    .last_of_item_o  (last_of_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic amre_pkg::level_e level_of(input logic [7:0] a);
    amre_pkg::level_e l;
    l = amre_pkg::LVL_FULL;
    if (a < amre_pkg::THR_FULL) l = amre_pkg::LVL_HIGH;
    if (a < amre_pkg::THR_HIGH) l = amre_pkg::LVL_LOW;
    if (a < amre_pkg::THR_LOW) l = amre_pkg::LVL_NONE;
    return l;
  endfunction

  function automatic int unsigned coverage_of(input amre_pkg::level_e l);
    case (l)
      amre_pkg::LVL_LOW:  return 32'(amre_pkg::COV_LOW);
      amre_pkg::LVL_HIGH: return 32'(amre_pkg::COV_HIGH);
      amre_pkg::LVL_FULL: return 32'(amre_pkg::COV_FULL);
      default:            return 0;
    endcase
  endfunction

  // Close the open run: scale the draw alpha by its coverage, rounded to nearest.
  function automatic span_t closed_span(input int start, input int len);
    span_t s;
    int unsigned scaled;
    scaled = (32'(color_q[31:24]) * coverage_of(open_level) + 32'(amre_pkg::DIV_ROUND)) / 255;
    s.row = 4'(pix_row);
    s.start = 4'(start);
    s.len = 5'(len);
    s.color = {8'(scaled), color_q[23:0]};
    s.last = 1'b0;
    return s;
  endfunction

  // Advance the run state by one pixel; queue the runs it closes when asked.
  function automatic void encode_pixel(input logic [7:0] a, input bit keep);
    span_t            runs [2];
    amre_pkg::level_e lvl;
    int               n;
    lvl = level_of(a);
    n = 0;
    if (pix_col == 0) begin
      open_start = 0;
      open_level = lvl;
    end else if (lvl != open_level) begin
      // level change: close the open run, drop it if it has no coverage
      if (open_level != amre_pkg::LVL_NONE) begin
        runs[n] = closed_span(open_start, pix_col - open_start);
        n++;
      end
      open_start = pix_col;
      open_level = lvl;
    end
    if (pix_col >= MASK - 1) begin
      // row end: the open run includes this pixel
      if (open_level != amre_pkg::LVL_NONE) begin
        runs[n] = closed_span(open_start, MASK - open_start);
        n++;
      end
      pix_col = 0;
      open_start = 0;
      pix_row = (pix_row + 1 >= MASK) ? 0 : pix_row + 1;
    end else begin
      pix_col++;
    end
    if (n > 0) runs[n-1].last = 1'b1;
    if (keep) begin
      for (int i = 0; i < n; i++) pending_spans.push_back(runs[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: all three channels sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    span_t want;
    if (rst_n) begin
      // Check outputs first: a run never comes out on the edge its pixel goes in.
      if (out_valid && out_ready) begin
        runs_seen++;
        if (pending_spans.size() == 0) begin
          $error("unexpected run: row %0d start %0d length %0d color 0x%0h",
                 run_row, run_start, run_length, run_color);
          n_errors++;
        end else begin
          want = pending_spans.pop_front();
          check_field("run_row", 32'(want.row), 32'(run_row));
          check_field("run_start", 32'(want.start), 32'(run_start));
          check_field("run_length", 32'(want.len), 32'(run_length));
          check_field("run_color", want.color, run_color);
          check_field("last_of_item", 32'(want.last), 32'(last_of_item));
        end
      end
      if (cfg_valid && cfg_ready) color_q = cfg_color;
      if (in_valid && in_ready) begin
        pixels_seen++;
        encode_pixel(mask_alpha, cur_n_typed == PREDICTED);
        if (cur_n_typed > 0) pending_spans.push_back(cur_s0);
        if (cur_n_typed > 1) pending_spans.push_back(cur_s1);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d runs outstanding",
                 STALL_LIMIT, pending_spans.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks: inputs change on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [7:0] a, input int n_typed, input span_t s0,
                            input span_t s1);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mask_alpha <= a;
    cur_n_typed <= n_typed;
    cur_s0 <= s0;
    cur_s1 <= s1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering pixels and hold until every queued run has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(input logic [31:0] c);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_color <= c;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_pixel(input logic [7:0] a, input int n_typed,
                                    input span_t s0, input span_t s1);
    dir_pixel_t p;
    p.alpha = a;
    p.n_typed = n_typed;
    p.s0 = s0;
    p.s1 = s1;
    directed_pixels.push_back(p);
  endfunction

  // Pick a byte that quantizes to the given level, often right on a band edge.
  function automatic logic [7:0] alpha_in_band(input amre_pkg::level_e l);
    int lo;
    int hi;
    case (l)
      amre_pkg::LVL_NONE: begin
        lo = 0;
        hi = int'(amre_pkg::THR_LOW) - 1;
      end
      amre_pkg::LVL_LOW: begin
        lo = int'(amre_pkg::THR_LOW);
        hi = int'(amre_pkg::THR_HIGH) - 1;
      end
      amre_pkg::LVL_HIGH: begin
        lo = int'(amre_pkg::THR_HIGH);
        hi = int'(amre_pkg::THR_FULL) - 1;
      end
      default: begin
        lo = int'(amre_pkg::THR_FULL);
        hi = 255;
      end
    endcase
    case ($urandom_range(7))
      0:       return 8'(lo);
      1:       return 8'(hi);
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0]      seg_colors [6];
    int               tx_pct [3];
    int               rx_pct [3];
    int               sent;
    int               len;
    amre_pkg::level_e lvl;

    seg_colors = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h01FF_00FF, $urandom, 32'hFE00_FF00,
                   $urandom};
    tx_pct = '{23, 52, 0};
    rx_pct = '{52, 23, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Row 0 under the reset color: every band edge, each level change, and a row
    // end that closes two runs at once. Row 1 is left to the predictor.
    add_pixel(8'd255, 0, '0, '0);
    add_pixel(8'd255, 0, '0, '0);
    add_pixel(8'd0,   1, '{4'd0, 4'd0, 5'd2, 32'hFFFF_FFFF, 1'b1}, '0);
    add_pixel(8'd23,  0, '0, '0);
    add_pixel(8'd24,  0, '0, '0);   // rising out of zero coverage: nothing closes
    add_pixel(8'd111, 0, '0, '0);
    add_pixel(8'd112, 1, '{4'd0, 4'd4, 5'd2, 32'h50FF_FFFF, 1'b1}, '0);
    add_pixel(8'd207, 0, '0, '0);
    add_pixel(8'd208, 1, '{4'd0, 4'd6, 5'd2, 32'hB0FF_FFFF, 1'b1}, '0);
    repeat (6) add_pixel(8'd255, 0, '0, '0);
    add_pixel(8'd80,  2, '{4'd0, 4'd8, 5'd7, 32'hFFFF_FFFF, 1'b0},
                         '{4'd0, 4'd15, 5'd1, 32'h50FF_FFFF, 1'b1});
    foreach (seg_colors[i]) begin
      if (i < 2) add_pixel(8'd3 + 8'(i) * 8'd197, PREDICTED, '0, '0);
    end
    add_pixel(8'd200, PREDICTED, '0, '0);
    add_pixel(8'd130, PREDICTED, '0, '0);
    add_pixel(8'd254, PREDICTED, '0, '0);
    add_pixel(8'd1,   PREDICTED, '0, '0);
    add_pixel(8'd100, PREDICTED, '0, '0);
    add_pixel(8'd150, PREDICTED, '0, '0);

    tx_idle_pct = tx_pct[0];
    rx_idle_pct = rx_pct[0];
    foreach (directed_pixels[i]) begin
      send_pixel(directed_pixels[i].alpha, directed_pixels[i].n_typed,
                 directed_pixels[i].s0, directed_pixels[i].s1);
    end
    drain();

    // Random part: six segments, two per idling mix, each under a new draw color.
    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = tx_pct[seg / 2];
      rx_idle_pct = rx_pct[seg / 2];
      write_color(seg_colors[seg]);
      // hold the receiver off while pixels keep coming, so the queue fills
      if (seg == 4) rx_hold_req = 1'b1;
      sent = 0;
      while (sent < SEG_PIXELS) begin
        if ($urandom_range(9) == 0) begin
          send_pixel(8'($urandom_range(255)), PREDICTED, '0, '0);
          sent++;
        end else begin
          // a run of one level with random bytes inside the band
          lvl = amre_pkg::level_e'($urandom_range(3));
          len = ($urandom_range(3) == 0) ? int'($urandom_range(2 * MASK, 7))
                                         : int'($urandom_range(6, 1));
          repeat (len) send_pixel(alpha_in_band(lvl), PREDICTED, '0, '0);
          sent += len;
        end
      end
      drain();
    end

    $display("Run covered %0d pixels (%0d mask rows) and %0d runs checked,",
             pixels_seen, pixels_seen / MASK, runs_seen);
    $display("under the reset color and 6 written colors, across three idling mixes.");
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/amre_pkg.sv
rtl/alpha_mask_run_encoder_top.sv
verif/alpha_mask_run_encoder_top_tb.sv
